>>> rtl/rau_pkg.sv
// Package: widths, state codes and operation codes for the rational arithmetic unit.
package rau_pkg;

   localparam int OPERAND_WIDTH = 32;
   localparam int MAG_WIDTH     = OPERAND_WIDTH;
   localparam int WIDE_WIDTH    = 64;
   localparam int CNT_WIDTH     = $clog2(WIDE_WIDTH + 1);

   typedef enum logic [1:0] {
      ACT_ADD = 2'd0,
      ACT_SUB = 2'd1,
      ACT_MUL = 2'd2,
      ACT_DIV = 2'd3
   } action_type;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_GCD1   = 10'b0000000010,
      ST_DIVA   = 10'b0000000100,
      ST_DIVB   = 10'b0000001000,
      ST_MUL    = 10'b0000010000,
      ST_COMB   = 10'b0000100000,
      ST_GCD2   = 10'b0001000000,
      ST_DIVN   = 10'b0010000000,
      ST_DIVD   = 10'b0100000000,
      ST_OUT    = 10'b1000000000
   } state_type;

   typedef enum logic [1:0] {
      MP_T1 = 2'd0,
      MP_T2 = 2'd1,
      MP_D  = 2'd2
   } mulph_type;

endpackage

>>> rtl/rational_arithmetic_unit.sv
// Rational arithmetic unit: add/sub/mul/div of two fractions with GCD reduction.
// Binary GCD steps (one per cycle), bit-serial restoring divisions and shift-add
// multiplies run on shared 64-bit subtract/compare logic plus one accumulator adder.
// The run time of each request is data dependent.
// Throughput: one request at a time; req_stall is high until the result is taken.
// Reset: synchronous, active high, returns the sequencer to idle and drops rsp_valid.
module rational_arithmetic_unit
   import rau_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_action,
   input  logic signed [31:0]     req_a_num,
   input  logic signed [31:0]     req_a_den,
   input  logic signed [31:0]     req_b_num,
   input  logic signed [31:0]     req_b_den,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [63:0]     rsp_res_num,
   output logic [62:0]            rsp_res_den,
   output logic                   rsp_res_valid
);

   localparam logic [CNT_WIDTH-1:0] LAST_BIT = CNT_WIDTH'(WIDE_WIDTH - 1);

   state_type               state_ff, state_in;
   mulph_type               mph_ff, mph_in;
   logic [1:0]              act_ff, act_in;
   logic [MAG_WIDTH-1:0]    an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic                    sa_ff, sa_in, sb_ff, sb_in, neg_ff, neg_in;
   // Shared working registers: x/y for GCD (x also accumulates the multiply), rem/quo for division
   logic [WIDE_WIDTH-1:0]   x_ff, x_in, y_ff, y_in;
   logic [WIDE_WIDTH-1:0]   rem_ff, rem_in, quo_ff, quo_in, dvd_ff, dvd_in;
   logic [WIDE_WIDTH-1:0]   t1_ff, t1_in, t2_ff, t2_in, n_ff, n_in, d_ff, d_in;
   logic [WIDE_WIDTH-1:0]   g_ff, g_in, qa_ff, qa_in;
   logic [CNT_WIDTH-1:0]    cnt_ff, cnt_in;
   logic [CNT_WIDTH-1:0]    k_ff, k_in;
   logic                    rv_ff, rv_in;
   logic [WIDE_WIDTH-1:0]   onum_ff, onum_in;
   logic [62:0]             oden_ff, oden_in;

   // Shared subtractor
   logic [WIDE_WIDTH-1:0]   sub_a, sub_b, sub_r;
   logic                    sub_ge;
   logic [WIDE_WIDTH:0]     sub_full;

   logic                    dn, nd, ndz;
   logic [MAG_WIDTH-1:0]    m_an, m_ad, m_bn, m_bd;
   logic [WIDE_WIDTH-1:0]   rem_sh;

   function automatic logic [MAG_WIDTH:0] dec(input logic [31:0] raw);
      logic [MAG_WIDTH-1:0] v;
      logic                 s;
      v = raw[MAG_WIDTH-1:0];
      s = v[MAG_WIDTH-1];
      return {s, s ? (~v + 1'b1) : v};
   endfunction

   assign {dn, m_an} = dec(req_a_num);
   assign {nd, m_ad} = dec(req_a_den);
   assign {ndz, m_bn} = dec(req_b_num);

   assign sub_full = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_r    = sub_full[WIDE_WIDTH-1:0];
   assign sub_ge   = ~sub_full[WIDE_WIDTH];
   assign rem_sh   = {rem_ff[WIDE_WIDTH-2:0], dvd_ff[WIDE_WIDTH-1]};

   // Operand select for the shared subtractor
   always_comb begin
      sub_a = x_ff;
      sub_b = y_ff;
      case (state_ff)
         ST_GCD1, ST_GCD2: begin
            sub_a = x_ff;
            sub_b = y_ff;
         end
         ST_DIVA, ST_DIVB, ST_DIVN, ST_DIVD: begin
            sub_a = rem_sh;
            sub_b = g_ff;
         end
         ST_COMB: begin
            sub_a = t1_ff;
            sub_b = t2_ff;
         end
         default: begin
            sub_a = x_ff;
            sub_b = y_ff;
         end
      endcase
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = (state_ff == ST_OUT);
   assign rsp_res_num   = onum_ff;
   assign rsp_res_den   = oden_ff;
   assign rsp_res_valid = rv_ff;

   // Sequencer
   always_comb begin
      logic                 sgn_bd;
      logic [MAG_WIDTH-1:0] mbd;
      logic [WIDE_WIDTH-1:0] nq;
      state_in = state_ff;  mph_in = mph_ff;  act_in = act_ff;
      an_in = an_ff;  ad_in = ad_ff;  bn_in = bn_ff;  bd_in = bd_ff;
      sa_in = sa_ff;  sb_in = sb_ff;  neg_in = neg_ff;
      x_in = x_ff;  y_in = y_ff;  rem_in = rem_ff;  quo_in = quo_ff;  dvd_in = dvd_ff;
      t1_in = t1_ff;  t2_in = t2_ff;  n_in = n_ff;  d_in = d_ff;  g_in = g_ff;
      qa_in = qa_ff;  cnt_in = cnt_ff;  k_in = k_ff;  rv_in = rv_ff;
      onum_in = onum_ff;  oden_in = oden_ff;
      {sgn_bd, mbd} = dec(req_b_den);
      nq = {quo_ff[WIDE_WIDTH-2:0], sub_ge};
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               act_in = req_action;
               an_in = m_an;  ad_in = m_ad;  bn_in = m_bn;  bd_in = mbd;
               sa_in = dn ^ nd;
               sb_in = ndz ^ sgn_bd;
               x_in = WIDE_WIDTH'(m_ad);
               y_in = WIDE_WIDTH'(mbd);
               k_in = '0;
               if (m_ad == '0 || mbd == '0 ||
                   (action_type'(req_action) == ACT_DIV && m_bn == '0)) begin
                  rv_in = 1'b0;  onum_in = '0;  oden_in = '0;
                  state_in = ST_OUT;
               end else if (req_action[1]) begin
                  // multiply / divide: products formed by shift-add
                  mph_in = MP_T1;
                  x_in = '0;  cnt_in = '0;
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_GCD1;
               end
            end
         end
         // Binary GCD: common factors of two are counted in k, an even value is
         // halved, two odd values give larger minus smaller (swap first if x < y).
         ST_GCD1, ST_GCD2: begin
            if (x_ff == '0 || y_ff == '0) begin
               g_in = (x_ff | y_ff) << k_ff;
               rem_in = '0;  quo_in = '0;  cnt_in = '0;
               if (state_ff == ST_GCD1) begin
                  dvd_in = WIDE_WIDTH'(ad_ff);
                  state_in = ST_DIVA;
               end else begin
                  dvd_in = n_ff;
                  state_in = ST_DIVN;
               end
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;  y_in = y_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (sub_ge) begin
               x_in = sub_r;
            end else begin
               x_in = y_ff;  y_in = x_ff;
            end
         end
         // Restoring division, one quotient bit per cycle
         ST_DIVA, ST_DIVB, ST_DIVN, ST_DIVD: begin
            rem_in = sub_ge ? sub_r : rem_sh;
            dvd_in = {dvd_ff[WIDE_WIDTH-2:0], 1'b0};
            quo_in = nq;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_BIT) begin
               rem_in = '0;  quo_in = '0;  cnt_in = '0;
               case (state_ff)
                  ST_DIVA: begin
                     qa_in = nq;
                     dvd_in = WIDE_WIDTH'(bd_ff);
                     state_in = ST_DIVB;
                  end
                  ST_DIVB: begin
                     // qa = ad/g, nq = bd/g; products next
                     quo_in = nq;
                     mph_in = MP_T1;  x_in = '0;
                     state_in = ST_MUL;
                  end
                  ST_DIVN: begin
                     n_in = nq;
                     dvd_in = d_ff;
                     state_in = ST_DIVD;
                  end
                  default: begin
                     onum_in = neg_ff && (n_ff != '0) ? ('0 - n_ff) : n_ff;
                     oden_in = nq[62:0];
                     rv_in = 1'b1;
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         // Shift-add multiply, one multiplier bit per cycle into x
         ST_MUL: begin
            logic [WIDE_WIDTH-1:0] mc, ml;
            mc = '0;  ml = '0;
            case (mph_ff)
               MP_T1: begin
                  mc = act_ff[1] ? WIDE_WIDTH'(an_ff) : WIDE_WIDTH'(an_ff);
                  ml = act_ff[1] ? (act_ff[0] ? WIDE_WIDTH'(bd_ff) : WIDE_WIDTH'(bn_ff))
                                 : quo_ff;
               end
               MP_T2: begin
                  mc = act_ff[1] ? WIDE_WIDTH'(ad_ff) : WIDE_WIDTH'(bn_ff);
                  ml = act_ff[1] ? (act_ff[0] ? WIDE_WIDTH'(bn_ff) : WIDE_WIDTH'(bd_ff))
                                 : qa_ff;
               end
               default: begin
                  mc = WIDE_WIDTH'(bd_ff);
                  ml = qa_ff;
               end
            endcase
            if (ml[cnt_ff[CNT_WIDTH-2:0]])
               x_in = x_ff + (mc << cnt_ff[CNT_WIDTH-2:0]);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_WIDTH'(MAG_WIDTH - 1)) begin
               cnt_in = '0;  x_in = '0;
               case (mph_ff)
                  MP_T1: begin
                     t1_in = ml[cnt_ff[CNT_WIDTH-2:0]] ?
                             x_ff + (mc << cnt_ff[CNT_WIDTH-2:0]) : x_ff;
                     mph_in = MP_T2;
                  end
                  MP_T2: begin
                     t2_in = ml[cnt_ff[CNT_WIDTH-2:0]] ?
                             x_ff + (mc << cnt_ff[CNT_WIDTH-2:0]) : x_ff;
                     if (act_ff[1]) begin
                        mph_in = MP_T1;
                        state_in = ST_COMB;
                     end else begin
                        mph_in = MP_D;
                     end
                  end
                  default: begin
                     d_in = ml[cnt_ff[CNT_WIDTH-2:0]] ?
                            x_ff + (mc << cnt_ff[CNT_WIDTH-2:0]) : x_ff;
                     mph_in = MP_T1;
                     state_in = ST_COMB;
                  end
               endcase
            end
         end
         // Combine terms into numerator/denominator and sign
         ST_COMB: begin
            if (act_ff[1]) begin
               n_in = t1_ff;  d_in = t2_ff;
               neg_in = sa_ff ^ sb_ff;
            end else begin
               logic sbx;
               sbx = sb_ff ^ act_ff[0];
               if (sa_ff == sbx) begin
                  n_in = t1_ff + t2_ff;  neg_in = sa_ff;
               end else if (sub_ge) begin
                  n_in = sub_r;  neg_in = sa_ff;
               end else begin
                  n_in = t2_ff - t1_ff;  neg_in = sbx;
               end
            end
            x_in = act_ff[1] ? t1_ff :
                   ((sa_ff == (sb_ff ^ act_ff[0])) ? t1_ff + t2_ff :
                    (sub_ge ? sub_r : t2_ff - t1_ff));
            y_in = act_ff[1] ? t2_ff : d_ff;
            k_in = '0;
            state_in = ST_GCD2;
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mph_ff   <= MP_T1;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         mph_ff   <= mph_in;
         cnt_ff   <= cnt_in;
      end
      act_ff <= act_in;  an_ff <= an_in;  ad_ff <= ad_in;  bn_ff <= bn_in;  bd_ff <= bd_in;
      sa_ff <= sa_in;  sb_ff <= sb_in;  neg_ff <= neg_in;
      x_ff <= x_in;  y_ff <= y_in;  rem_ff <= rem_in;  quo_ff <= quo_in;  dvd_ff <= dvd_in;
      t1_ff <= t1_in;  t2_ff <= t2_in;  n_ff <= n_in;  d_ff <= d_in;  g_ff <= g_in;
      qa_ff <= qa_in;  k_ff <= k_in;  rv_ff <= rv_in;
      onum_ff <= onum_in;  oden_ff <= oden_in;
   end

endmodule

>>> tb/sv/rational_arithmetic_unit_tb.sv
// Testbench for the rational arithmetic unit: directed and random requests vs. a predictor.
module rational_arithmetic_unit_tb;
   import rau_pkg::*;

   typedef struct {
      logic signed [63:0] num;
      logic [62:0]        den;
      logic               ok;
   } fraction_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_action = ACT_ADD;
   logic signed [31:0] req_a_num = '0, req_a_den = '0, req_b_num = '0, req_b_den = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [63:0] rsp_res_num;
   logic [62:0] rsp_res_den;
   logic rsp_res_valid;

   fraction_type expected_q[$];
   int fail_count = 0;
   int sent_count = 0;
   int recv_count = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_cycles = 0;
   int op_seen[4] = '{0, 0, 0, 0};

   localparam int WATCHDOG_LIMIT = 20000;

   rational_arithmetic_unit dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // magnitude of an operand
   function automatic logic [63:0] mag_of(input logic signed [31:0] v);
      return v[31] ? 64'(-65'(v)) : 64'(v);
   endfunction

   function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   // predicted reduced fraction for one request
   function automatic fraction_type reduce_rational(input logic [1:0] act,
         input logic signed [31:0] an, input logic signed [31:0] ad,
         input logic signed [31:0] bn, input logic signed [31:0] bd);
      fraction_type r;
      logic [63:0] man, mad, mbn, mbd, gd, t1, t2, n, d, g;
      logic sa, sb, neg;
      man = mag_of(an); mad = mag_of(ad); mbn = mag_of(bn); mbd = mag_of(bd);
      sa = an[31] ^ ad[31];
      sb = bn[31] ^ bd[31];
      neg = 1'b0;
      if (mad == 0 || mbd == 0 || (act == ACT_DIV && mbn == 0)) begin
         r.num = '0; r.den = '0; r.ok = 1'b0;
         return r;
      end
      case (act)
         ACT_ADD, ACT_SUB: begin
            gd = gcd64(mad, mbd);
            t1 = man * (mbd / gd);
            t2 = mbn * (mad / gd);
            if (act == ACT_SUB) sb = ~sb;
            if (sa == sb) begin
               n = t1 + t2; neg = sa;
            end else if (t1 >= t2) begin
               n = t1 - t2; neg = sa;
            end else begin
               n = t2 - t1; neg = sb;
            end
            d = (mad / gd) * mbd;
         end
         ACT_MUL: begin
            n = man * mbn; d = mad * mbd; neg = sa ^ sb;
         end
         default: begin
            n = man * mbd; d = mbn * mad; neg = sa ^ sb;
         end
      endcase
      g = gcd64(n, d);
      n = n / g;
      d = d / g;
      if (n == 0) neg = 1'b0;
      r.num = neg ? -n : n;
      r.den = d[62:0];
      r.ok = 1'b1;
      return r;
   endfunction

   // send one request; valid stays high across back-to-back requests
   task automatic send_request(input logic [1:0] act, input logic signed [31:0] an,
         input logic signed [31:0] ad, input logic signed [31:0] bn,
         input logic signed [31:0] bd);
      while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_a_num <= an; req_a_den <= ad; req_b_num <= bn; req_b_den <= bd;
      expected_q.push_back(reduce_rational(act, an, ad, bn, bd));
      op_seen[act]++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drain();
      drop_valid();
      while (expected_q.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [31:0] rand_operand(input int kind);
      case (kind)
         0: return $signed($urandom_range(15, 0)) - 8;
         1: return $signed($urandom_range(2000, 0)) - 1000;
         2: return $signed($urandom);
         default: begin
            case ($urandom_range(4, 0))
               0: return 32'sh80000000;
               1: return 32'sh7fffffff;
               2: return 32'sh0;
               3: return -32'sd1;
               default: return 32'sd1;
            endcase
         end
      endcase
   endfunction

   // response stall generator: random percentage or a long hold-off
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (stall_pct > 0) && ($urandom_range(99, 0) < stall_pct);
      end
   end

   // response checker
   always @(posedge clock) begin
      fraction_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         recv_count++;
         if (expected_q.size() == 0) begin
            $error("unexpected response num=%0d den=%0d", rsp_res_num, rsp_res_den);
            fail_count++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_res_num !== e.num) begin
               $error("res_num expected %0d actual %0d", e.num, rsp_res_num);
               fail_count++;
            end
            if (rsp_res_den !== e.den) begin
               $error("res_den expected %0d actual %0d", e.den, rsp_res_den);
               fail_count++;
            end
            if (rsp_res_valid !== e.ok) begin
               $error("res_valid expected %0b actual %0b", e.ok, rsp_res_valid);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", idle_cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic test_directed();
      logic signed [31:0] ext[5];
      ext = '{32'sh80000000, 32'sh7fffffff, 32'sd0, -32'sd1, 32'sd1};
      send_request(ACT_ADD, 1, 2, 1, 3);
      send_request(ACT_SUB, 1, 2, 1, 2);
      send_request(ACT_MUL, -3, -4, 2, 3);
      send_request(ACT_DIV, 3, 4, -3, 8);
      send_request(ACT_ADD, 5, 0, 1, 1);
      send_request(ACT_SUB, 1, 1, 5, 0);
      send_request(ACT_DIV, 7, 3, 0, 5);
      send_request(ACT_MUL, 0, 7, 9, -4);
      send_request(ACT_SUB, -2, 3, -4, -6);
      for (int i = 0; i < 4; i++) begin
         send_request(action_type'(i), ext[0], ext[0], ext[0], ext[0]);
         send_request(action_type'(i), ext[1], ext[0], ext[0], ext[1]);
         send_request(action_type'(i), ext[0], ext[1], ext[1], ext[3]);
         send_request(action_type'(i), ext[1], ext[1], ext[3], ext[1]);
      end
      wait_drain();
   endtask

   task automatic test_random(input int count, input int sidle, input int spct);
      int kind;
      send_idle_pct = sidle;
      stall_pct = spct;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(3, 0);
         send_request(2'($urandom), rand_operand(kind), rand_operand(kind),
                      rand_operand($urandom_range(3, 0)), rand_operand(kind));
      end
      wait_drain();
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   task automatic test_backpressure();
      hold_cycles = 3000;
      for (int i = 0; i < 20; i++)
         send_request(2'($urandom), rand_operand(1), rand_operand(1), rand_operand(1),
                      rand_operand(1));
      wait_drain();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random(450, 0, 0);
      test_random(450, 84, 0);
      test_random(450, 0, 84);
      test_random(430, 19, 19);
      test_backpressure();
      repeat (800) @(negedge clock);
      $display("Covered %0d requests (add %0d, sub %0d, mul %0d, div %0d), %0d responses,",
               sent_count, op_seen[0], op_seen[1], op_seen[2], op_seen[3], recv_count);
      $display("including operand extremes, zero denominators and a long response hold-off.");
      if (fail_count == 0 && expected_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
